@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the checker file dpu_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DPU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DPU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/dpu_pkg.sv @@
`default_nettype none

package dpu_pkg;

    // Image limits
    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PAL_DEPTH_DEF = 256;

    // Register map
    localparam int NUM_REGS = 5;
    localparam int PADDR_W  = $clog2(4 * NUM_REGS);

    localparam logic [2:0] REG_FORMAT = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_PITCH  = 3'd3;
    localparam logic [2:0] REG_BOTTOM = 3'd4;

    // Item opcodes
    localparam logic OP_PAL = 1'b0;
    localparam logic OP_PIX = 1'b1;

    // Pixel formats
    localparam logic [2:0] FMT_1BPP  = 3'd0;
    localparam logic [2:0] FMT_4BPP  = 3'd1;
    localparam logic [2:0] FMT_8BPP  = 3'd2;
    localparam logic [2:0] FMT_16BPP = 3'd3;
    localparam logic [2:0] FMT_24BPP = 3'd4;
    localparam logic [2:0] FMT_32BPP = 3'd5;

    // How a queued byte turns into pixels
    localparam logic [1:0] KIND_MONO   = 2'd0;
    localparam logic [1:0] KIND_PAL    = 2'd1;
    localparam logic [1:0] KIND_DIRECT = 2'd2;

    // Settings in effect, derived from the registers
    typedef struct packed {
        logic [2:0]  fmt;
        logic        fmt_ok;
        logic [12:0] w;
        logic [11:0] wm1;
        logic [12:0] h;
        logic [11:0] hm1;
        logic [14:0] data_bytes;
        logic [14:0] stride;
        logic        bottom_up;
    } cfg_t;

    // One byte's worth of pixels waiting for palette data
    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  cnt_m1;
        logic [7:0]  bits;
        logic [23:0] rgb;
        logic [11:0] col;
        logic [11:0] row;
        logic        last_row;
        logic        black0;
        logic        black1;
    } job_t;

    // Palette memory request
    typedef struct packed {
        logic        we;
        logic [7:0]  waddr;
        logic [23:0] wdata;
        logic        re;
        logic [7:0]  raddr0;
        logic [7:0]  raddr1;
    } pal_req_t;

endpackage

`default_nettype wire

@@ hw/rtl/dpu_in_if.sv @@
`default_nettype none

interface dpu_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;

    modport source (
        output valid, opcode, data_byte, palette_index, palette_color,
        input  ready
    );
    modport sink (
        input  valid, opcode, data_byte, palette_index, palette_color,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/dpu_out_if.sv @@
`default_nettype none

interface dpu_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] column;
    logic [11:0] row;
    logic        last_of_run;
    logic        frame_done;

    modport source (
        output valid, red, green, blue, column, row, last_of_run, frame_done,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, column, row, last_of_run, frame_done,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/dpu_cfg_regs.sv @@
`default_nettype none

module dpu_cfg_regs
    import dpu_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output cfg_t                    cfg,
    output logic                    cfg_restart,
    output logic                    cfg_hold
);

    logic [2:0]  fmt_reg;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [14:0] pitch_reg;
    logic        bu_reg;
    logic        hold_reg;
    cfg_t        cfg_reg;
    cfg_t        cfg_next;

    logic        wr;
    logic [2:0]  idx;
    logic [14:0] pitch_sat;
    logic [14:0] db_round;

    assign pready = 1'b1;
    assign idx    = paddr[PADDR_W-1:2];
    assign wr     = psel && penable && pwrite;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_8BPP;
            width_reg  <= 13'd1;
            height_reg <= 13'd1;
            pitch_reg  <= 15'd0;
            bu_reg     <= 1'b1;
        end
        else if (wr)
        begin
            case (idx)
                REG_FORMAT: fmt_reg    <= pwdata[2:0];
                REG_WIDTH:  width_reg  <= pwdata[12:0];
                REG_HEIGHT: height_reg <= pwdata[12:0];
                REG_PITCH:  pitch_reg  <= pwdata[14:0];
                REG_BOTTOM: bu_reg     <= pwdata[0];
                default:    ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        case (idx)
            REG_FORMAT: prdata = {29'd0, fmt_reg};
            REG_WIDTH:  prdata = {19'd0, width_reg};
            REG_HEIGHT: prdata = {19'd0, height_reg};
            REG_PITCH:  prdata = {17'd0, pitch_reg};
            REG_BOTTOM: prdata = {31'd0, bu_reg};
            default:    prdata = 32'd0;
        endcase
    end

    // Settings in effect: clamped sizes, row data length and stride
    always_comb
    begin
        cfg_next           = '0;
        cfg_next.fmt       = fmt_reg;
        cfg_next.fmt_ok    = (fmt_reg inside {[FMT_1BPP:FMT_32BPP]});
        cfg_next.bottom_up = bu_reg;

        if (width_reg == 13'd0)
            cfg_next.w = 13'd1;
        else if ({19'd0, width_reg} > 32'(MAX_WIDTH))
            cfg_next.w = 13'(MAX_WIDTH);
        else
            cfg_next.w = width_reg;

        if (height_reg == 13'd0)
            cfg_next.h = 13'd1;
        else if ({19'd0, height_reg} > 32'(MAX_HEIGHT))
            cfg_next.h = 13'(MAX_HEIGHT);
        else
            cfg_next.h = height_reg;

        cfg_next.wm1 = 12'(cfg_next.w - 13'd1);
        cfg_next.hm1 = 12'(cfg_next.h - 13'd1);

        case (fmt_reg)
            FMT_1BPP:  cfg_next.data_bytes = (15'(cfg_next.w) + 15'd7) >> 3;
            FMT_4BPP:  cfg_next.data_bytes = (15'(cfg_next.w) + 15'd1) >> 1;
            FMT_8BPP:  cfg_next.data_bytes = 15'(cfg_next.w);
            FMT_16BPP: cfg_next.data_bytes = 15'(cfg_next.w) << 1;
            FMT_24BPP: cfg_next.data_bytes = 15'(cfg_next.w) + (15'(cfg_next.w) << 1);
            FMT_32BPP: cfg_next.data_bytes = 15'(cfg_next.w) << 2;
            default:   cfg_next.data_bytes = 15'd1;
        endcase

        db_round  = (cfg_next.data_bytes + 15'd3) & ~15'd3;
        pitch_sat = ({17'd0, pitch_reg} > 32'(4 * MAX_WIDTH)) ? 15'(4 * MAX_WIDTH)
                                                                : pitch_reg;
        if (pitch_reg == 15'd0)
            cfg_next.stride = db_round;
        else if (pitch_sat < cfg_next.data_bytes)
            cfg_next.stride = cfg_next.data_bytes;
        else
            cfg_next.stride = pitch_sat;
    end

    // Derived settings are registered after a write; hold input until they settle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg  <= '0;
            hold_reg <= 1'b1;
        end
        else
        begin
            cfg_reg  <= cfg_next;
            hold_reg <= wr;
        end
    end

    assign cfg         = cfg_reg;
    assign cfg_hold    = hold_reg;
    assign cfg_restart = wr && ({29'd0, idx} < 32'(NUM_REGS));

endmodule

`default_nettype wire

@@ hw/rtl/dpu_palette_ram.sv @@
`default_nettype none

module dpu_palette_ram
    import dpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  pal_req_t   pal_req,
    output logic [23:0] rd0,
    output logic [23:0] rd1
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [23:0] pal_mem [PALETTE_DEPTH];
    logic [23:0] rd0_reg;
    logic [23:0] rd1_reg;

    // One write port
    always_ff @(posedge clk)
    begin
        if (pal_req.we)
            pal_mem[pal_req.waddr[AW-1:0]] <= pal_req.wdata;
    end

    // Two read ports, registered data held until the next read
    always_ff @(posedge clk)
    begin
        if (pal_req.re)
        begin
            rd0_reg <= pal_mem[pal_req.raddr0[AW-1:0]];
            rd1_reg <= pal_mem[pal_req.raddr1[AW-1:0]];
        end
    end

    assign rd0 = rd0_reg;
    assign rd1 = rd1_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dpu_row_tracker.sv @@
`default_nettype none

module dpu_row_tracker
    import dpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    dpu_in_if.sink    pix_in,
    input  cfg_t      cfg,
    input  wire logic cfg_restart,
    input  wire logic cfg_hold,
    input  wire logic job_take,
    output logic      job_valid,
    output job_t      job,
    output pal_req_t  pal_req
);

    // Position state
    logic [13:0] bir_reg,     bir_next;
    logic [12:0] col_reg,     col_next;
    logic [12:0] row_reg,     row_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  bip_reg,     bip_next;
    logic        jv_reg,      jv_next;
    job_t        job_reg,     job_next;

    logic        accept;
    logic        pix_go;
    logic        in_data;
    logic        job_new;
    logic        emit_direct;
    logic        row_end;
    logic [14:0] bir_inc;
    logic [12:0] col_rem;
    logic [2:0]  cnt_m1;
    logic [3:0]  col_adv;
    logic [1:0]  bip_last;
    logic [23:0] p_new;
    logic [23:0] rgb_direct;
    logic [7:0]  b;
    logic [7:0]  idx0;
    logic [7:0]  idx1;

    assign b            = pix_in.data_byte;
    assign pix_in.ready = !cfg_hold && (!jv_reg || job_take);
    assign accept       = pix_in.valid && pix_in.ready;
    assign pix_go       = accept && (pix_in.opcode == OP_PIX) && cfg.fmt_ok
                          && (row_reg < cfg.h);
    assign in_data      = ({1'b0, bir_reg} < cfg.data_bytes);
    assign bir_inc      = {1'b0, bir_reg} + 15'd1;
    assign row_end      = (bir_inc >= cfg.stride);

    // Palette writes and lookups
    assign idx0 = (cfg.fmt == FMT_4BPP) ? {4'd0, b[7:4]} : b;
    assign idx1 = {4'd0, b[3:0]};

    always_comb
    begin
        pal_req.we     = accept && (pix_in.opcode == OP_PAL)
                         && ({1'b0, pix_in.palette_index} < 9'(PALETTE_DEPTH));
        pal_req.waddr  = pix_in.palette_index;
        pal_req.wdata  = pix_in.palette_color;
        pal_req.re     = pix_go;
        pal_req.raddr0 = idx0;
        pal_req.raddr1 = idx1;
    end

    // Pixels this byte yields in the packed modes
    always_comb
    begin
        col_rem = cfg.w - col_reg;
        case (cfg.fmt)
            FMT_1BPP: cnt_m1 = (col_rem >= 13'd8) ? 3'd7 : (col_rem[2:0] - 3'd1);
            FMT_4BPP: cnt_m1 = (col_rem >= 13'd2) ? 3'd1 : 3'd0;
            default:  cnt_m1 = 3'd0;
        endcase
        col_adv = {1'b0, cnt_m1} + 4'd1;
    end

    // Multi-byte pixel assembly, bytes arrive low first
    always_comb
    begin
        case (cfg.fmt)
            FMT_16BPP: bip_last = 2'd1;
            FMT_24BPP: bip_last = 2'd2;
            default:   bip_last = 2'd3;
        endcase
        case (bip_reg)
            2'd0:    p_new = partial_reg | {16'd0, b};
            2'd1:    p_new = partial_reg | {8'd0, b, 8'd0};
            2'd2:    p_new = partial_reg | {b, 16'd0};
            default: p_new = partial_reg;
        endcase
        if (cfg.fmt == FMT_16BPP)
            rgb_direct = {p_new[14:10], 3'd0, p_new[9:5], 3'd0, p_new[4:0], 3'd0};
        else
            rgb_direct = p_new;
        emit_direct = (bip_reg == bip_last);
    end

    always_comb
    begin
        case (cfg.fmt)
            FMT_1BPP, FMT_4BPP, FMT_8BPP: job_new = pix_go && in_data;
            default:                      job_new = pix_go && in_data && emit_direct;
        endcase
    end

    // Position update
    always_comb
    begin
        bir_next     = bir_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        partial_next = partial_reg;
        bip_next     = bip_reg;

        if (cfg_restart)
        begin
            bir_next     = 14'd0;
            col_next     = 13'd0;
            row_next     = 13'd0;
            partial_next = 24'd0;
            bip_next     = 2'd0;
        end
        else if (pix_go)
        begin
            if (in_data)
            begin
                if (cfg.fmt inside {FMT_1BPP, FMT_4BPP, FMT_8BPP})
                    col_next = col_reg + 13'(col_adv);
                else if (emit_direct)
                begin
                    col_next     = col_reg + 13'd1;
                    partial_next = 24'd0;
                    bip_next     = 2'd0;
                end
                else
                begin
                    partial_next = p_new;
                    bip_next     = bip_reg + 2'd1;
                end
            end
            if (row_end)
            begin
                bir_next     = 14'd0;
                col_next     = 13'd0;
                partial_next = 24'd0;
                bip_next     = 2'd0;
                row_next     = row_reg + 13'd1;
            end
            else
                bir_next = bir_inc[13:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bir_reg     <= 14'd0;
            col_reg     <= 13'd0;
            row_reg     <= 13'd0;
            partial_reg <= 24'd0;
            bip_reg     <= 2'd0;
            jv_reg      <= 1'b0;
        end
        else
        begin
            bir_reg     <= bir_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            partial_reg <= partial_next;
            bip_reg     <= bip_next;
            jv_reg      <= jv_next;
        end
    end

    // Job slot, waits here while the palette read completes
    always_comb
    begin
        jv_next = jv_reg;
        if (job_new)
            jv_next = 1'b1;
        else if (job_take)
            jv_next = 1'b0;

        job_next = job_reg;
        if (job_new)
        begin
            case (cfg.fmt)
                FMT_1BPP:           job_next.kind = KIND_MONO;
                FMT_4BPP, FMT_8BPP: job_next.kind = KIND_PAL;
                default:            job_next.kind = KIND_DIRECT;
            endcase
            job_next.cnt_m1   = cnt_m1;
            job_next.bits     = b;
            job_next.rgb      = rgb_direct;
            job_next.col      = col_reg[11:0];
            job_next.row      = cfg.bottom_up ? (cfg.hm1 - row_reg[11:0]) : row_reg[11:0];
            job_next.last_row = (row_reg[11:0] == cfg.hm1);
            job_next.black0   = ({1'b0, idx0} >= 9'(PALETTE_DEPTH));
            job_next.black1   = ({1'b0, idx1} >= 9'(PALETTE_DEPTH));
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

    assign job_valid = jv_reg;
    assign job       = job_reg;

endmodule

`default_nettype wire

@@ hw/rtl/dpu_pixel_expander.sv @@
`default_nettype none

module dpu_pixel_expander
    import dpu_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  cfg_t       cfg,
    input  wire logic  job_valid,
    input  job_t       job,
    input  wire logic [23:0] rd0,
    input  wire logic [23:0] rd1,
    output logic       job_take,
    dpu_out_if.source  pix_out
);

    logic        ex_valid_reg, ex_valid_next;
    logic [2:0]  remain_reg,   remain_next;
    logic [11:0] col_reg,      col_next;
    logic [11:0] row_reg,      row_next;
    logic [7:0]  bits_reg,     bits_next;
    logic [1:0]  kind_reg,     kind_next;
    logic [23:0] cur_reg,      cur_next;
    logic [23:0] alt_reg,      alt_next;
    logic        lrow_reg,     lrow_next;

    logic out_fire;
    logic run_end;

    assign out_fire = ex_valid_reg && pix_out.ready;
    assign run_end  = (remain_reg == 3'd0);
    assign job_take = job_valid && (!ex_valid_reg || (out_fire && run_end));

    // Load a byte's pixels, then step through them one per taken item
    always_comb
    begin
        ex_valid_next = ex_valid_reg;
        remain_next   = remain_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        bits_next     = bits_reg;
        kind_next     = kind_reg;
        cur_next      = cur_reg;
        alt_next      = alt_reg;
        lrow_next     = lrow_reg;

        if (job_take)
        begin
            ex_valid_next = 1'b1;
            remain_next   = job.cnt_m1;
            col_next      = job.col;
            row_next      = job.row;
            bits_next     = job.bits;
            kind_next     = job.kind;
            lrow_next     = job.last_row;
            alt_next      = job.black1 ? 24'd0 : rd1;
            case (job.kind)
                KIND_MONO: cur_next = {24{job.bits[7]}};
                KIND_PAL:  cur_next = job.black0 ? 24'd0 : rd0;
                default:   cur_next = job.rgb;
            endcase
        end
        else if (out_fire)
        begin
            if (run_end)
                ex_valid_next = 1'b0;
            else
            begin
                remain_next = remain_reg - 3'd1;
                col_next    = col_reg + 12'd1;
                bits_next   = {bits_reg[6:0], 1'b0};
                cur_next    = (kind_reg == KIND_MONO) ? {24{bits_reg[6]}} : alt_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ex_valid_reg <= 1'b0;
        else
            ex_valid_reg <= ex_valid_next;
    end

    always_ff @(posedge clk)
    begin
        remain_reg <= remain_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        bits_reg   <= bits_next;
        kind_reg   <= kind_next;
        cur_reg    <= cur_next;
        alt_reg    <= alt_next;
        lrow_reg   <= lrow_next;
    end

    // Output register drives the channel
    assign pix_out.valid       = ex_valid_reg;
    assign pix_out.red         = cur_reg[23:16];
    assign pix_out.green       = cur_reg[15:8];
    assign pix_out.blue        = cur_reg[7:0];
    assign pix_out.column      = col_reg;
    assign pix_out.row         = row_reg;
    assign pix_out.last_of_run = run_end;
    assign pix_out.frame_done  = lrow_reg && (col_reg == cfg.wm1);

endmodule

`default_nettype wire

@@ hw/rtl/dib_pixel_unpacker.sv @@
// Bitmap pixel-row unpacker.
// Input channel pix_in: one item per byte. opcode 1 carries a pixel data byte,
// opcode 0 writes palette_color into palette entry palette_index.
// Output channel pix_out: one item per decoded pixel, RGB with column and row;
// last_of_run marks the final pixel from a byte, frame_done the image's last.
// APB port: format, width, height, row pitch and bottom-up flag; any write to
// these registers restarts the frame at row 0, column 0 and keeps the palette.
// Throughput: one input item per cycle unless a register write is settling
// or the output holds it back. Each pixel takes one output item, so a 1 bpp
// byte holds the output for up to 8 pixels and a 4 bpp byte for 2; 8 bpp runs
// at one byte per cycle and 16/24/32 bpp at one pixel per 2/3/4 bytes. A byte
// is held in the job slot with its palette read, then in the output register.
// Reset: position counters clear and registers take their defaults; palette
// contents are unknown until written. pix_in.ready is low for one cycle after
// reset and after each register write while the derived settings settle.
// Stall: while pix_out.ready is low the output holds; one further byte waits
// in the lookup stage and then pix_in.ready drops.
`default_nettype none

module dib_pixel_unpacker
    import dpu_pkg::*;
#(
    parameter int PALETTE_DEPTH = PAL_DEPTH_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    dpu_in_if.sink                  pix_in,
    dpu_out_if.source               pix_out
);

    cfg_t        cfg;
    logic        cfg_restart;
    logic        cfg_hold;
    logic        job_valid;
    logic        job_take;
    job_t        job;
    pal_req_t    pal_req;
    logic [23:0] rd0;
    logic [23:0] rd1;

    // Registers
    dpu_cfg_regs u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cfg         (cfg),
        .cfg_restart (cfg_restart),
        .cfg_hold    (cfg_hold)
    );

    // Byte intake and row position
    dpu_row_tracker #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix_in      (pix_in),
        .cfg         (cfg),
        .cfg_restart (cfg_restart),
        .cfg_hold    (cfg_hold),
        .job_take    (job_take),
        .job_valid   (job_valid),
        .job         (job),
        .pal_req     (pal_req)
    );

    // Palette memory
    dpu_palette_ram #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_pal (
        .clk     (clk),
        .pal_req (pal_req),
        .rd0     (rd0),
        .rd1     (rd1)
    );

    // Pixel output
    dpu_pixel_expander u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job       (job),
        .rd0       (rd0),
        .rd1       (rd1),
        .job_take  (job_take),
        .pix_out   (pix_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dpu_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module dpu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  red,
    input wire logic [7:0]  green,
    input wire logic [7:0]  blue,
    input wire logic [11:0] column,
    input wire logic [11:0] row,
    input wire logic        last_of_run,
    input wire logic        frame_done
);

    // A stalled pixel keeps its payload
    `DPU_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, $stable(red) && $stable(green) && $stable(blue) && $stable(column) && $stable(row), "stalled pixel changed")

    // The image's final pixel always closes its byte's run
    `DPU_ASSERT_IMP(a_frame_run, clk, rst_n, out_valid && frame_done, last_of_run, "frame_done without last_of_run")

    // Pixels of one byte follow on at the next column
    `DPU_ASSERT_NXT(a_run_step, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid && (column == $past(column) + 12'd1), "run column did not step")

    // Input pauses for a cycle after every register write
    `DPU_ASSERT_NXT(a_cfg_pause, clk, rst_n, psel && penable && pwrite, !in_ready, "input taken right after a register write")

endmodule

bind dib_pixel_unpacker dpu_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .in_ready    (pix_in.ready),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .red         (pix_out.red),
    .green       (pix_out.green),
    .blue        (pix_out.blue),
    .column      (pix_out.column),
    .row         (pix_out.row),
    .last_of_run (pix_out.last_of_run),
    .frame_done  (pix_out.frame_done)
);

`default_nettype wire

@@ test/tb_dib_pixel_unpacker.sv @@
`timescale 1ns / 100ps

module tb_dib_pixel_unpacker;
    import dpu_pkg::*;

    localparam int IDLE_PERCENT   = 16;
    localparam int STEADY_ITEMS   = 100;
    localparam int RANDOM_ITEMS   = 240;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 6;
    localparam int END_CYCLES     = 12;
    localparam int QUIET_LIMIT    = 1000;
    localparam int REG_SLOTS      = 1 << (PADDR_W - 2);
    localparam int PITCH_FIELD_MAX = 32767;
    localparam int DIM_FIELD_MAX  = 8191;

    // formats the block does not decode
    localparam logic [2:0] FMT_SPARE_A = 3'd6;
    localparam logic [2:0] FMT_SPARE_B = 3'd7;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_of_run;
        logic        frame_done;
    } pixel_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    dpu_in_if  pix_in_if ();
    dpu_out_if pix_out_if ();

    dib_pixel_unpacker uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix_in  (pix_in_if),
        .pix_out (pix_out_if)
    );

    // Decoder state as the block should hold it
    logic [23:0] palette_model [256];
    bit          palette_known [256];
    logic [2:0]  fmt_setting       = FMT_8BPP;
    logic [12:0] width_setting     = 13'd1;
    logic [12:0] height_setting    = 13'd1;
    logic [14:0] pitch_setting     = 15'd0;
    logic        bottom_up_setting = 1'b1;
    int          byte_pos   = 0;
    int          col_pos    = 0;
    int          row_pos    = 0;
    int          pixel_byte = 0;
    logic [23:0] pixel_acc  = 24'd0;

    pixel_t pending_pixels [$];
    pixel_t pixel_run [$];
    pixel_t want;

    int failures     = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_request = 1'b0;
    bit steady_run   = 1'b0;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Row geometry from the current settings
    function automatic void frame_geometry(output int w, output int h, output int data_len,
                                           output int stride, output int bpp);
        int pitch;
        w = (width_setting == 0) ? 1 :
            (width_setting > MAX_WIDTH ? MAX_WIDTH : int'(width_setting));
        h = (height_setting == 0) ? 1 :
            (height_setting > MAX_HEIGHT ? MAX_HEIGHT : int'(height_setting));
        case (fmt_setting)
            FMT_1BPP:  bpp = 1;
            FMT_4BPP:  bpp = 4;
            FMT_8BPP:  bpp = 8;
            FMT_16BPP: bpp = 16;
            FMT_24BPP: bpp = 24;
            default:   bpp = 32;
        endcase
        data_len = (w * bpp + 7) / 8;
        if (pitch_setting == 0)
        begin
            stride = ((w * bpp + 31) / 32) * 4;
        end
        else
        begin
            pitch  = (pitch_setting > 4 * MAX_WIDTH) ? 4 * MAX_WIDTH : int'(pitch_setting);
            stride = (pitch < data_len) ? data_len : pitch;
        end
    endfunction

    // One pixel at the current column; columns past the width give nothing
    function automatic void put_pixel(input logic [23:0] rgb, input int w, input int h);
        pixel_t px;
        if (pixel_run.size() < 8 && col_pos < w)
        begin
            px.red         = rgb[23:16];
            px.green       = rgb[15:8];
            px.blue        = rgb[7:0];
            px.column      = 12'(col_pos);
            px.row         = bottom_up_setting ? 12'(h - 1 - row_pos) : 12'(row_pos);
            px.last_of_run = 1'b0;
            px.frame_done  = (col_pos == w - 1) && (row_pos == h - 1);
            pixel_run.push_back(px);
        end
        if (col_pos < w)
            col_pos++;
    endfunction

    // Pixels that one accepted item gives
    function automatic void predict_pixels(input logic op, input logic [7:0] data,
                                           input logic [7:0] idx, input logic [23:0] colour);
        int          w, h, data_len, stride, bpp;
        logic [15:0] word;
        pixel_t      px;
        if (op == OP_PAL)
        begin
            palette_model[idx] = colour;
            return;
        end
        if (fmt_setting > FMT_32BPP)
            return;
        frame_geometry(w, h, data_len, stride, bpp);
        if (row_pos >= h)
            return;
        pixel_run.delete();
        if (byte_pos < data_len)
        begin
            case (fmt_setting)
                FMT_1BPP:
                begin
                    for (int k = 7; k >= 0; k--)
                        put_pixel(data[k] ? 24'hFFFFFF : 24'h000000, w, h);
                end
                FMT_4BPP:
                begin
                    put_pixel(palette_model[{4'h0, data[7:4]}], w, h);
                    put_pixel(palette_model[{4'h0, data[3:0]}], w, h);
                end
                FMT_8BPP:
                    put_pixel(palette_model[data], w, h);
                default:
                begin
                    // bytes come blue first; a 32 bpp alpha byte is dropped
                    if (pixel_byte < 3)
                        pixel_acc = pixel_acc | (24'(data) << (8 * pixel_byte));
                    pixel_byte++;
                    if (pixel_byte >= bpp / 8)
                    begin
                        if (fmt_setting == FMT_16BPP)
                        begin
                            word = pixel_acc[15:0];
                            put_pixel({word[14:10], 3'b000, word[9:5], 3'b000,
                                       word[4:0], 3'b000}, w, h);
                        end
                        else
                        begin
                            put_pixel(pixel_acc, w, h);
                        end
                        pixel_byte = 0;
                        pixel_acc  = 24'd0;
                    end
                end
            endcase
        end
        // row end, padding included
        byte_pos++;
        if (byte_pos >= stride)
        begin
            byte_pos   = 0;
            col_pos    = 0;
            pixel_acc  = 24'd0;
            pixel_byte = 0;
            row_pos++;
        end
        foreach (pixel_run[k])
        begin
            px = pixel_run[k];
            px.last_of_run = (k == pixel_run.size() - 1);
            pending_pixels.push_back(px);
        end
    endfunction

    function automatic void check_field(input string field_name, input logic [23:0] want_v,
                                        input logic [23:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t ns: pixel %s mismatch, expected %0d, got %0d",
                     $time, field_name, want_v, got_v);
            failures++;
        end
    endfunction

    // Send one item; predicts its pixels at acceptance
    task automatic send_item(input logic op, input logic [7:0] data, input logic [7:0] idx,
                             input logic [23:0] colour);
        bit accepted;
        if (!steady_run)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                pix_in_if.valid <= 1'b0;
                @(posedge clk);
            end
        end
        pix_in_if.valid         <= 1'b1;
        pix_in_if.opcode        <= op;
        pix_in_if.data_byte     <= data;
        pix_in_if.palette_index <= idx;
        pix_in_if.palette_color <= colour;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = pix_in_if.ready;
            if (accepted)
                predict_pixels(op, data, idx, colour);
            @(posedge clk);
        end
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [23:0] colour);
        palette_known[idx] = 1'b1;
        send_item(OP_PAL, 8'($urandom), idx, colour);
    endtask

    task automatic ensure_palette(input logic [7:0] idx);
        if (!palette_known[idx])
            send_palette(idx, 24'($urandom));
    endtask

    // Pixel byte; entries it may look up are written first
    task automatic send_pixel(input logic [7:0] data);
        if (fmt_setting == FMT_8BPP)
        begin
            ensure_palette(data);
        end
        else if (fmt_setting == FMT_4BPP)
        begin
            ensure_palette({4'h0, data[7:4]});
            ensure_palette({4'h0, data[3:0]});
        end
        send_item(OP_PIX, data, 8'($urandom), 24'($urandom));
    endtask

    // Wait for every pending pixel, then let the pipeline empty
    task automatic wait_drained();
        pix_in_if.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB transfer: setup, then access; write lands at the closing edge
    task automatic apb_access(input logic write, input int index, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= PADDR_W'(4 * index);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input int index);
        logic [31:0] got_v, want_v;
        apb_access(1'b0, index, 32'd0, got_v);
        case (index)
            REG_FORMAT: want_v = 32'(fmt_setting);
            REG_WIDTH:  want_v = 32'(width_setting);
            REG_HEIGHT: want_v = 32'(height_setting);
            REG_PITCH:  want_v = 32'(pitch_setting);
            default:    want_v = 32'(bottom_up_setting);
        endcase
        if (got_v !== want_v)
        begin
            $display("%0t ns: register %0d readback mismatch, expected %0d, got %0d",
                     $time, index, want_v, got_v);
            failures++;
        end
    endtask

    // Register write with random bits above the field, then readback if it is in the map
    task automatic write_reg(input int index, input int unsigned value);
        logic [31:0] mask, wdata, unused;
        case (index)
            REG_FORMAT: mask = 32'h7;
            REG_WIDTH:  mask = 32'h1FFF;
            REG_HEIGHT: mask = 32'h1FFF;
            REG_PITCH:  mask = 32'h7FFF;
            REG_BOTTOM: mask = 32'h1;
            default:    mask = 32'h0;
        endcase
        wdata = (value & mask) | ($urandom() & ~mask);
        apb_access(1'b1, index, wdata, unused);
        if (index < NUM_REGS)
        begin
            case (index)
                REG_FORMAT: fmt_setting       = wdata[2:0];
                REG_WIDTH:  width_setting     = wdata[12:0];
                REG_HEIGHT: height_setting    = wdata[12:0];
                REG_PITCH:  pitch_setting     = wdata[14:0];
                default:    bottom_up_setting = wdata[0];
            endcase
            // any write restarts the frame, palette kept
            byte_pos   = 0;
            col_pos    = 0;
            row_pos    = 0;
            pixel_acc  = 24'd0;
            pixel_byte = 0;
            check_reg(index);
        end
    endtask

    task automatic configure(input logic [2:0] fmt, input int width, input int height,
                             input int pitch, input bit bottom);
        wait_drained();
        write_reg(REG_FORMAT, fmt);
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_BOTTOM, bottom);
        write_reg(REG_PITCH, pitch);
    endtask

    // Reset values, then a 1x1 bottom-up 8 bpp frame with bytes past its end
    task automatic test_register_defaults();
        for (int k = 0; k < NUM_REGS; k++)
            check_reg(k);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
    endtask

    // 1 bpp, msb first, pixels past the width dropped, two rows top-down
    task automatic test_mono_rows();
        configure(FMT_1BPP, 11, 2, 0, 1'b0);
        send_pixel(8'h80);
        send_pixel(8'h01);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        send_pixel(8'hFF);
        send_pixel(8'hE0);
    endtask

    // 4 bpp palette lookups, odd width, explicit pitch
    task automatic test_palette_nibbles();
        configure(FMT_4BPP, 3, 1, 6, 1'b1);
        send_pixel(8'hF0);
        send_pixel(8'h1E);
    endtask

    // 5-5-5, 24 bpp with a pitch below the data length, 32 bpp with alpha
    task automatic test_direct_colour();
        configure(FMT_16BPP, 2, 1, 0, 1'b0);
        send_pixel(8'hFF);
        send_pixel(8'h7F);
        send_pixel(8'h00);
        send_pixel(8'h80);
        configure(FMT_24BPP, 1, 2, 2, 1'b1);
        send_pixel(8'h01);
        send_pixel(8'h02);
        send_pixel(8'h03);
        send_pixel(8'hC0);
        send_pixel(8'hB0);
        send_pixel(8'hA0);
        configure(FMT_32BPP, 1, 1, 0, 1'b0);
        send_pixel(8'h10);
        send_pixel(8'h20);
        send_pixel(8'h30);
        send_pixel(8'hFF);
    endtask

    // Zero and oversize dimensions, huge pitch, unknown formats, spare registers
    task automatic test_corner_settings();
        configure(FMT_8BPP, 0, 0, PITCH_FIELD_MAX, 1'b1);
        send_pixel(8'($urandom));
        send_pixel(8'($urandom));
        configure(FMT_SPARE_A, 4, 1, 0, 1'b0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        configure(FMT_SPARE_B, 4, 1, 0, 1'b0);
        send_pixel(8'h5A);
        configure(FMT_1BPP, DIM_FIELD_MAX, DIM_FIELD_MAX, 0, 1'b1);
        send_pixel(8'hA5);
        // writes outside the map must not restart the frame
        wait_drained();
        for (int k = NUM_REGS; k < REG_SLOTS; k++)
            write_reg(k, $urandom);
        send_pixel(8'h5A);
    endtask

    // A register write mid-frame drops the partial pixel and restarts at row 0
    task automatic test_frame_restart();
        configure(FMT_24BPP, 3, 2, 0, 1'b0);
        repeat (5) send_pixel(8'($urandom));
        wait_drained();
        write_reg(REG_BOTTOM, 1);
        repeat (3) send_pixel(8'($urandom));
    endtask

    // Output held off for a long stretch while input keeps coming
    task automatic test_output_stall();
        configure(FMT_1BPP, 64, 2, 0, 1'b1);
        steady_run   = 1'b1;
        hold_request = 1'b1;
        repeat (16) send_pixel(8'($urandom));
        steady_run = 1'b0;
    endtask

    // Random settings, mostly whole small frames, some cut short or overrun
    task automatic test_random_frames();
        int         items_sent, pick, width, height, count, frame_len;
        int         w, h, data_len, stride, bpp;
        logic [2:0] fmt;
        items_sent = 0;
        steady_run = 1'b1;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= STEADY_ITEMS)
                steady_run = 1'b0;
            pick = $urandom_range(0, 15);
            if (pick == 14)
                fmt = FMT_SPARE_A;
            else if (pick == 15)
                fmt = FMT_SPARE_B;
            else
                fmt = 3'(pick % 6);
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0:       width = 0;
                    1:       width = MAX_WIDTH;
                    2:       width = DIM_FIELD_MAX;
                    default: width = $urandom_range(13, MAX_WIDTH);
                endcase
            end
            else
            begin
                width = $urandom_range(1, 10);
            end
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       height = 0;
                    1:       height = MAX_HEIGHT;
                    default: height = DIM_FIELD_MAX;
                endcase
            end
            else
            begin
                height = $urandom_range(1, 3);
            end
            configure(fmt, width, height, 0, 1'($urandom_range(0, 1)));
            frame_geometry(w, h, data_len, stride, bpp);
            pick = $urandom_range(0, 7);
            if (pick == 7)
                write_reg(REG_PITCH, $urandom_range(4 * MAX_WIDTH, PITCH_FIELD_MAX));
            else if (pick >= 4)
                write_reg(REG_PITCH, $urandom_range(1, data_len + 5));
            frame_geometry(w, h, data_len, stride, bpp);

            if (fmt > FMT_32BPP)
            begin
                // ignored bytes, not counted
                repeat ($urandom_range(2, 5)) send_pixel(8'($urandom));
            end
            else
            begin
                frame_len = stride * h;
                if (frame_len <= 120 && $urandom_range(0, 5) != 0)
                    count = frame_len + $urandom_range(0, 2);
                else
                    count = $urandom_range(1, frame_len < 24 ? frame_len : 24);
                for (int k = 0; k < count; k++)
                begin
                    if ($urandom_range(0, 11) == 0)
                    begin
                        send_palette(8'($urandom), 24'($urandom));
                        items_sent++;
                    end
                    send_pixel(8'($urandom));
                    if (k < frame_len)
                        items_sent++;
                end
            end
        end
        steady_run = 1'b0;
    endtask

    // Output ready: random stalls, steady stretches and one long hold-off
    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            pix_out_if.ready <= 1'b0;
            hold_left--;
        end
        else if (steady_run)
        begin
            pix_out_if.ready <= 1'b1;
        end
        else
        begin
            pix_out_if.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Pixel checker, sampled mid-cycle ahead of the accepting edge
    always @(negedge clk)
    begin
        if (rst_n && pix_out_if.valid && pix_out_if.ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t ns: pixel with none expected, column %0d row %0d",
                         $time, pix_out_if.column, pix_out_if.row);
                failures++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                check_field("red", want.red, pix_out_if.red);
                check_field("green", want.green, pix_out_if.green);
                check_field("blue", want.blue, pix_out_if.blue);
                check_field("column", want.column, pix_out_if.column);
                check_field("row", want.row, pix_out_if.row);
                check_field("last_of_run", want.last_of_run, pix_out_if.last_of_run);
                check_field("frame_done", want.frame_done, pix_out_if.frame_done);
            end
        end
    end

    // Watchdog on cycles with no handshake on any port
    always @(negedge clk)
    begin
        if (!rst_n || psel || (pix_in_if.valid && pix_in_if.ready) ||
            (pix_out_if.valid && pix_out_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t ns: timeout, %0d pixels still expected", $time, pending_pixels.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        rst_n                    = 1'b0;
        psel                     = 1'b0;
        penable                  = 1'b0;
        pwrite                   = 1'b0;
        paddr                    = '0;
        pwdata                   = 32'd0;
        pix_in_if.valid          = 1'b0;
        pix_in_if.opcode         = OP_PIX;
        pix_in_if.data_byte      = 8'd0;
        pix_in_if.palette_index  = 8'd0;
        pix_in_if.palette_color  = 24'd0;
        pix_out_if.ready         = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_register_defaults();
        test_mono_rows();
        test_palette_nibbles();
        test_direct_colour();
        test_corner_settings();
        test_frame_restart();
        test_output_stall();
        test_random_frames();

        wait_drained();
        repeat (END_CYCLES) @(posedge clk);
        if (failures == 0 && pending_pixels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
